// ===== rtl/core/ldate_pkg.sv =====
package ldate_pkg;

    // Table geometry and field widths
    localparam int unsigned ROM_ROWS  = 68;
    localparam int unsigned ROW_W     = $clog2(ROM_ROWS);
    localparam int unsigned DAY_W     = 15;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned LDAY_W    = 5;

    // Calendar constants
    localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
    localparam logic [LDAY_W-1:0]  DAY_FIRST     = 5'd1;
    localparam logic [LDAY_W-1:0]  DAY_SHORT     = 5'd29;
    localparam logic [LDAY_W-1:0]  DAY_LONG      = 5'd30;
    localparam logic [15:0]        DAYS_PER_YEAR = 16'd365;
    localparam logic [15:0]        JAN_DAYS      = 16'd31;

    // One lunar year: long-month flags (bit k = month k+1), leap month
    // (zero for none), new year in February, and new-year day of month.
    typedef struct packed {
        logic [11:0] longs;
        logic [3:0]  leap;
        logic        feb;
        logic [4:0]  ny_day;
    } rom_row_t;

    localparam rom_row_t LUNAR_ROM [ROM_ROWS] = '{
        '{12'b101101101001, 4'd0,  1'b1, 5'd6},
        '{12'b101110110010, 4'd5,  1'b0, 5'd27},
        '{12'b101101010010, 4'd0,  1'b1, 5'd15},
        '{12'b101100100101, 4'd0,  1'b1, 5'd3},
        '{12'b101100101011, 4'd4,  1'b0, 5'd23},
        '{12'b101001001011, 4'd0,  1'b1, 5'd11},
        '{12'b101010101011, 4'd8,  1'b0, 5'd31},
        '{12'b001010101101, 4'd0,  1'b1, 5'd18},
        '{12'b010101101101, 4'd0,  1'b1, 5'd7},
        '{12'b010110101001, 4'd6,  1'b0, 5'd28},
        '{12'b110110101001, 4'd0,  1'b1, 5'd16},
        '{12'b110110010010, 4'd0,  1'b1, 5'd5},
        '{12'b111010010101, 4'd4,  1'b0, 5'd25},
        '{12'b110100100101, 4'd0,  1'b1, 5'd13},
        '{12'b111001001101, 4'd10, 1'b1, 5'd2},
        '{12'b101001010110, 4'd0,  1'b1, 5'd20},
        '{12'b001010110110, 4'd0,  1'b1, 5'd9},
        '{12'b001011110101, 4'd6,  1'b0, 5'd29},
        '{12'b011011010101, 4'd0,  1'b1, 5'd17},
        '{12'b111010101001, 4'd0,  1'b1, 5'd6},
        '{12'b111101010010, 4'd5,  1'b0, 5'd27},
        '{12'b111010010010, 4'd0,  1'b1, 5'd15},
        '{12'b110100100110, 4'd0,  1'b1, 5'd4},
        '{12'b010100101110, 4'd3,  1'b0, 5'd23},
        '{12'b101001010111, 4'd0,  1'b1, 5'd10},
        '{12'b101011010110, 4'd8,  1'b0, 5'd31},
        '{12'b001101011010, 4'd0,  1'b1, 5'd19},
        '{12'b011011010101, 4'd0,  1'b1, 5'd7},
        '{12'b101101101001, 4'd5,  1'b0, 5'd28},
        '{12'b011101001001, 4'd0,  1'b1, 5'd16},
        '{12'b011010010011, 4'd0,  1'b1, 5'd5},
        '{12'b101010011011, 4'd4,  1'b0, 5'd24},
        '{12'b010100101011, 4'd0,  1'b1, 5'd12},
        '{12'b101001011011, 4'd0,  1'b1, 5'd1},
        '{12'b101010101110, 4'd2,  1'b0, 5'd22},
        '{12'b010101101010, 4'd0,  1'b1, 5'd9},
        '{12'b110111010101, 4'd7,  1'b0, 5'd29},
        '{12'b101110100100, 4'd0,  1'b1, 5'd18},
        '{12'b101101001001, 4'd0,  1'b1, 5'd7},
        '{12'b110101010011, 4'd5,  1'b0, 5'd26},
        '{12'b101010010101, 4'd0,  1'b1, 5'd14},
        '{12'b010100101101, 4'd0,  1'b1, 5'd3},
        '{12'b010101011101, 4'd4,  1'b0, 5'd23},
        '{12'b101010110101, 4'd0,  1'b1, 5'd10},
        '{12'b101110101010, 4'd9,  1'b0, 5'd31},
        '{12'b010111010010, 4'd0,  1'b1, 5'd19},
        '{12'b110110100101, 4'd0,  1'b1, 5'd8},
        '{12'b111010001010, 4'd6,  1'b0, 5'd28},
        '{12'b110101001010, 4'd0,  1'b1, 5'd16},
        '{12'b110010010101, 4'd0,  1'b1, 5'd5},
        '{12'b101010011110, 4'd4,  1'b0, 5'd25},
        '{12'b010101010110, 4'd0,  1'b1, 5'd12},
        '{12'b101010110101, 4'd0,  1'b1, 5'd1},
        '{12'b101011011010, 4'd2,  1'b0, 5'd22},
        '{12'b011011010010, 4'd0,  1'b1, 5'd10},
        '{12'b011101100101, 4'd6,  1'b0, 5'd29},
        '{12'b011100100101, 4'd0,  1'b1, 5'd17},
        '{12'b011001001011, 4'd0,  1'b1, 5'd6},
        '{12'b011001010111, 4'd5,  1'b0, 5'd26},
        '{12'b110010101011, 4'd0,  1'b1, 5'd13},
        '{12'b010101011010, 4'd0,  1'b1, 5'd3},
        '{12'b010101101110, 4'd3,  1'b0, 5'd23},
        '{12'b101101101001, 4'd0,  1'b1, 5'd11},
        '{12'b111101010010, 4'd11, 1'b0, 5'd31},
        '{12'b101101010010, 4'd0,  1'b1, 5'd19},
        '{12'b101100100101, 4'd0,  1'b1, 5'd8},
        '{12'b110100001011, 4'd6,  1'b0, 5'd28},
        '{12'b101001001011, 4'd0,  1'b1, 5'd15}
    };

    // Day count of a row's new year. Over the stored years every fourth
    // year from 1972 is a leap year (2000 included), so the leap days
    // before row r come to (r + 1) / 4.
    function automatic logic [DAY_W-1:0] ny_days(input logic [ROW_W-1:0] row);
        logic [15:0] acc;
        logic [ROW_W:0] row_p1;
        row_p1 = {1'b0, row} + {{ROW_W{1'b0}}, 1'b1};
        acc = 16'(row) * DAYS_PER_YEAR
            + 16'(row_p1 >> 2)
            + (LUNAR_ROM[row].feb ? JAN_DAYS : 16'd0)
            + 16'(LUNAR_ROM[row].ny_day)
            - 16'd1;
        return acc[DAY_W-1:0];
    endfunction

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WALK
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic search_step;
        logic walk_init;
        logic walk_step;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic year_hit;
        logic row_zero;
        logic walk_done;
    } dp_status_t;

endpackage

// ===== rtl/core/ldate_ctrl.sv =====
module ldate_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  ldate_pkg::dp_status_t status,
    output ldate_pkg::dp_cmd_t    cmd
);
    import ldate_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    // Output register is free when empty or being drained
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // Hit, or fell off the first year: start the month walk
                if (status.year_hit || status.row_zero) begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_WALK: begin
                if (status.walk_done) begin
                    if (out_free) begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

endmodule

// ===== rtl/core/ldate_dp.sv =====
module ldate_dp #(
    parameter int unsigned NUM_YEARS = 68
) (
    input  logic                              aclk,
    input  logic [ldate_pkg::DAY_W-1:0]       day_number,
    input  ldate_pkg::dp_cmd_t                cmd,
    output ldate_pkg::dp_status_t             status,
    output logic [ldate_pkg::MONTH_W-1:0]     lunar_month,
    output logic [ldate_pkg::LDAY_W-1:0]      lunar_day
);
    import ldate_pkg::*;

    localparam int unsigned SEARCH_ROWS = (NUM_YEARS < ROM_ROWS) ? NUM_YEARS : ROM_ROWS;
    localparam logic [ROW_W-1:0] START_ROW = ROW_W'(SEARCH_ROWS - 1);

    logic [DAY_W-1:0]   day_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [DAY_W-1:0]   left_reg;
    logic [MONTH_W-1:0] mon_reg;
    logic               pending_reg;   // next month change enters the leap month
    logic               in_leap_reg;   // walking the leap month
    logic [MONTH_W-1:0] month_out_reg;
    logic [LDAY_W-1:0]  day_out_reg;

    logic [DAY_W:0]     diff;
    rom_row_t           row_data;
    logic [MONTH_W-1:0] mon_idx;
    logic [MONTH_W-1:0] mon_inc;
    logic [LDAY_W-1:0]  len;
    logic               fits;
    logic               sat;
    logic [MONTH_W-1:0] res_month;
    logic [LDAY_W-1:0]  res_day;

    // Year search compare
    assign diff            = {1'b0, day_reg} - {1'b0, ny_days(row_reg)};
    assign status.year_hit = !diff[DAY_W];
    assign status.row_zero = (row_reg == '0);

    // Month walk: length of the current month and whether the date lies in it
    assign row_data = LUNAR_ROM[row_reg];
    assign mon_idx  = mon_reg - MONTH_FIRST;
    assign mon_inc  = mon_reg + MONTH_FIRST;
    assign len      = (!in_leap_reg && row_data.longs[mon_idx]) ? DAY_LONG : DAY_SHORT;
    assign fits     = (left_reg < DAY_W'(len));
    // Leaving the last month of the year saturates
    assign sat      = !fits && !pending_reg && (mon_reg == MONTH_LAST);
    assign status.walk_done = fits || sat;

    assign res_month = sat ? MONTH_LAST : mon_reg;
    assign res_day   = sat ? DAY_LONG : (left_reg[LDAY_W-1:0] + DAY_FIRST);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            day_reg <= day_number;
            row_reg <= START_ROW;
        end else if (cmd.search_step) begin
            row_reg <= row_reg - ROW_W'(1);
        end

        if (cmd.walk_init) begin
            left_reg    <= status.year_hit ? diff[DAY_W-1:0] : '0;
            mon_reg     <= MONTH_FIRST;
            pending_reg <= 1'b0;
            in_leap_reg <= 1'b0;
        end else if (cmd.walk_step) begin
            left_reg <= left_reg - DAY_W'(len);
            if (pending_reg) begin
                // Leap month repeats the current number
                pending_reg <= 1'b0;
                in_leap_reg <= 1'b1;
            end else begin
                mon_reg     <= mon_inc;
                in_leap_reg <= 1'b0;
                pending_reg <= (row_data.leap == mon_inc);
            end
        end

        if (cmd.out_load) begin
            month_out_reg <= res_month;
            day_out_reg   <= res_day;
        end
    end

    assign lunar_month = month_out_reg;
    assign lunar_day   = day_out_reg;

endmodule

// ===== rtl/core/lunar_date_from_day_count.sv =====
// Lunar date from a day count.
// The input channel (s_) takes one item: days since 1970-01-01 in
// s_tdata[14:0]. The result channel (m_) returns one item per input:
// lunar month in m_tdata[3:0], lunar day in m_tdata[8:4]; a leap month
// repeats its base month number. Dates before the 1970 lunar new year
// give month 1, day 1.
// One item is processed at a time. After acceptance the year search steps
// down one table row per cycle from the last stored year, then the month
// walk steps month by month through the found year; the result is registered
// at the end of the walk, once the output register is free, and the next
// item can be accepted in the cycle after the result is loaded.
// s_tready is high only while no item is in the search or walk.
// The result sits in an output register: a new item may be accepted and
// processed while it waits; if the receiver still stalls when the next
// result is done, the walk holds until the register drains.
// Reset (aresetn low, synchronous) returns the controller to idle and
// drops m_tvalid; no table clearing is needed.
module lunar_date_from_day_count #(
    parameter int unsigned NUM_YEARS = 68
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [14:0] day_number, [15] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [3:0] lunar_month, [8:4] lunar_day, [15:9] zero
);
    import ldate_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [MONTH_W-1:0] lunar_month;
    logic [LDAY_W-1:0]  lunar_day;

    ldate_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ldate_dp #(
        .NUM_YEARS (NUM_YEARS)
    ) u_dp (
        .aclk        (aclk),
        .day_number  (s_tdata[DAY_W-1:0]),
        .cmd         (cmd),
        .status      (status),
        .lunar_month (lunar_month),
        .lunar_day   (lunar_day)
    );

    assign m_tdata = {7'd0, lunar_day, lunar_month};

endmodule
